// ===== rtl/core/imu_cal_pkg.sv =====
// Package with shared constants, register indexes and types of the IMU calibrator.
`timescale 1ns / 1ps
package imu_cal_pkg;

  localparam int WindowLengthDefault = 25;
  localparam int NumRegs = 6;
  localparam int FieldWidth = 16;

  typedef enum logic [2:0] {
    REG_PITCH_OFF = 3'd0,
    REG_ROLL_OFF  = 3'd1,
    REG_YAW_OFF   = 3'd2,
    REG_AX_OFF    = 3'd3,
    REG_AY_OFF    = 3'd4,
    REG_AZ_OFF    = 3'd5
  } reg_index_t;

  // Soft-iron matrix in 1/1000 and hard-iron offsets in 1/100 uT.
  function automatic logic signed [11:0] soft_coef(input logic [3:0] idx);
    logic signed [11:0] c;
    case (idx)
      4'd0: c = 12'sd947;
      4'd1: c = -12'sd3;
      4'd2: c = 12'sd10;
      4'd3: c = -12'sd3;
      4'd4: c = 12'sd1022;
      4'd5: c = -12'sd23;
      4'd6: c = 12'sd10;
      4'd7: c = -12'sd23;
      4'd8: c = 12'sd1034;
      default: c = 12'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [13:0] hard_off(input logic [1:0] axis);
    logic signed [13:0] h;
    case (axis)
      2'd0: h = -14'sd2006;
      2'd1: h = -14'sd2812;
      2'd2: h = 14'sd4836;
      default: h = 14'sd0;
    endcase
    return h;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [47:0] v);
    logic [15:0] r;
    if (v > 48'sd32767) r = 16'h7FFF;
    else if (v < -48'sd32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/imu_sample_calibrator_top.sv =====
// Top level of the IMU sample calibrator: control sequencer, shared datapath and window.
`timescale 1ns / 1ps
// An item is accepted only while the sequencer is idle, so the next item is
// taken only once the last result has been moved to the output register. Most
// of the work is seven rounded divisions on a bit-serial divider (three field
// values, three rates and the window average); before them come nine soft-iron
// multiply-accumulate products, three rate products and three squares for the
// sum of squares, and a bit-serial square root for
// the magnitude runs alongside the divisions. Narrow multipliers (23x12 for the
// soft-iron products, 18x16 for the rates and 18x18 for the squares) each take
// one product per cycle. A finished result sits in an output register, so the
// next item is computed while it waits; the sequencer stalls before its own
// result if the previous one has still not been taken. The boxcar window is
// cleared at reset by valid bits, so no clearing pass is needed.
module imu_sample_calibrator_top
  import imu_cal_pkg::*;
#(
  parameter int WINDOW_LENGTH = WindowLengthDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // field_x/y/z, pitch/roll/yaw_rate, body_accel_x/y/z, accel_magnitude, average_z
  output logic [175:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  localparam int SlotW = $clog2(WINDOW_LENGTH);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b00000001,
    ST_MAC  = 8'b00000010,
    ST_RATE = 8'b00000100,
    ST_SQ   = 8'b00001000,
    ST_DIVS = 8'b00010000,
    ST_DIVW = 8'b00100000,
    ST_SQRW = 8'b01000000,
    ST_OUT  = 8'b10000000
  } state_t;

  state_t state;
  logic [15:0] offsets [NumRegs];
  logic [15:0] in_f [9];
  logic signed [47:0] num [7];   // numerators for the seven rounded divisions
  logic signed [47:0] acc;
  logic [3:0] step;
  logic [2:0] dsel;
  logic signed [17:0] body [3];
  logic [33:0] sumsq;
  logic [33:0] sq_rad;
  logic [15:0] res [11];
  logic [15:0] res_out [11];
  logic        busy_out;

  logic [15:0] hist [WINDOW_LENGTH];
  logic [WINDOW_LENGTH-1:0] hvalid;
  logic [SlotW-1:0] slot;
  logic signed [21:0] wsum;

  logic signed [17:0] ma;
  logic signed [15:0] mb;
  logic signed [33:0] prod;

  logic div_start, div_done, sq_start, sq_done;
  logic [39:0] div_dvd, div_q;
  logic [16:0] div_dvs;
  logic [16:0] root;
  logic signed [47:0] cur_num, rounded;
  logic [15:0] zsat, old_z;
  logic [1:0] mrow, mcol;

  imu_cal_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .offsets
  );

  imu_cal_serdiv u_div (
    .clk, .rst, .start(div_start), .dividend(div_dvd), .divisor(div_dvs),
    .done(div_done), .quotient(div_q)
  );

  imu_cal_sqrt u_sqrt (
    .clk, .rst, .start(sq_start), .radicand(sq_rad), .done(sq_done), .root
  );

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = busy_out;
  always_comb
    for (int k = 0; k < 11; k++) m_tdata[16*k +: 16] = res_out[k];

  // Magnetometer deltas d = mag*100 - off*16 stay within 23 bits signed.
  logic signed [22:0] dmag [3];
  always_comb
    for (int k = 0; k < 3; k++)
      dmag[k] = 23'(signed'(in_f[6+k]) * 23'sd100) - 23'(hard_off(2'(k)) * 23'sd16);

  // Matrix row and column of the current multiply-accumulate step.
  always_comb begin
    mrow = (step < 4'd3) ? 2'd0 : (step < 4'd6) ? 2'd1 : 2'd2;
    mcol = 2'(step - 4'({mrow, 1'b0}) - 4'(mrow));
  end

  // The coefficient has 12 bits, so the soft-iron product fits 35 bits.
  logic signed [34:0] mprod;
  always_comb begin
    mprod = 35'(dmag[mcol] * soft_coef(step));
    ma = '0;
    mb = '0;
    case (state)
      ST_RATE: begin
        ma = 18'sd1125;
        mb = signed'(in_f[step]);
      end
      ST_SQ: begin
        ma = 18'(body[step[1:0]]);
        mb = 16'sd0;
      end
      default: ;
    endcase
    prod = 34'(ma * mb);
  end

  logic signed [33:0] sqr;
  assign sqr = 34'(body[step[1:0]] * body[step[1:0]]);
  // The root starts on the last square, so that square is added on the way in.
  assign sq_rad = sumsq + sqr;

  assign zsat = sat16(48'(body[2]));
  assign cur_num = num[dsel];

  always_comb begin
    div_dvd = cur_num[47] ? 40'(-cur_num) : 40'(cur_num);
    div_dvs = (dsel < 3'd3) ? 17'd100000 : (dsel < 3'd6) ? 17'd1256 : 17'(WINDOW_LENGTH);
    div_dvd = div_dvd + 40'(div_dvs >> 1);
    rounded = cur_num[47] ? -48'(div_q) : 48'(div_q);
  end

  assign div_start = (state == ST_DIVS);
  assign sq_start  = (state == ST_SQ) && (step == 4'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      busy_out <= 1'b0;
      hvalid   <= '0;
      slot     <= '0;
      wsum     <= '0;
      step     <= '0;
      dsel     <= '0;
    end else begin
      if (m_tvalid && m_tready) busy_out <= 1'b0;
      unique case (state)
        ST_IDLE: if (s_tvalid && s_tready) begin
          for (int k = 0; k < 9; k++) in_f[k] <= s_tdata[16*k +: 16];
          step  <= '0;
          acc   <= '0;
          state <= ST_MAC;
        end
        ST_MAC: begin
          if (mcol == 2'd2) begin
            num[3'(mrow)] <= acc + 48'(mprod);
            acc <= '0;
          end else acc <= acc + 48'(mprod);
          if (step == 4'd8) begin
            step  <= '0;
            state <= ST_RATE;
          end else step <= step + 4'd1;
        end
        ST_RATE: begin
          num[3'd3 + 3'(step)] <= (step == 4'd2 ? -48'(prod) : 48'(prod))
            - 48'(signed'(offsets[3'(step)]) * 48'sd1256);
          body[0] <= -18'(signed'(in_f[4])) - 18'(signed'(offsets[3]));
          body[1] <= -18'(signed'(in_f[3])) - 18'(signed'(offsets[4]));
          body[2] <= 18'(signed'(in_f[5])) - 18'(signed'(offsets[5]));
          old_z <= hvalid[slot] ? hist[slot] : 16'h0000;
          if (step == 4'd2) begin
            step  <= '0;
            sumsq <= '0;
            state <= ST_SQ;
          end else step <= step + 4'd1;
        end
        ST_SQ: begin
          sumsq <= sumsq + 34'(sqr);
          if (step == 4'd2) begin
            res[6] <= sat16(48'(body[0]));
            res[7] <= sat16(48'(body[1]));
            res[8] <= zsat;
            wsum <= wsum + 22'(signed'(zsat)) - 22'(signed'(old_z));
            num[6] <= 48'(wsum + 22'(signed'(zsat)) - 22'(signed'(old_z)));
            hist[slot] <= zsat;
            hvalid[slot] <= 1'b1;
            slot <= (slot == SlotW'(WINDOW_LENGTH - 1)) ? '0 : slot + SlotW'(1);
            dsel  <= '0;
            state <= ST_DIVS;
          end else step <= step + 4'd1;
        end
        ST_DIVS: state <= ST_DIVW;
        ST_DIVW: if (div_done) begin
          res[(dsel == 3'd6) ? 4'd10 : 4'(dsel)] <= sat16(rounded);
          if (dsel == 3'd6) state <= ST_SQRW;
          else begin
            dsel  <= dsel + 3'd1;
            state <= ST_DIVS;
          end
        end
        ST_SQRW: begin
          res[9] <= (root > 17'd65535) ? 16'hFFFF : root[15:0];
          state <= ST_OUT;
        end
        ST_OUT: if (!busy_out) begin
          res_out  <= res;
          busy_out <= 1'b1;
          state    <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/imu_cal_regs.sv =====
// APB register file holding the six rate and acceleration offsets.
`timescale 1ns / 1ps
module imu_cal_regs
  import imu_cal_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] offsets [NumRegs]
);
  logic [2:0] ridx;
  assign ridx = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) offsets[i] <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_PITCH_OFF: offsets[0] <= pwdata[15:0];
        REG_ROLL_OFF:  offsets[1] <= pwdata[15:0];
        REG_YAW_OFF:   offsets[2] <= pwdata[15:0];
        REG_AX_OFF:    offsets[3] <= pwdata[15:0];
        REG_AY_OFF:    offsets[4] <= pwdata[15:0];
        REG_AZ_OFF:    offsets[5] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (ridx)
      REG_PITCH_OFF: prdata = {{16{offsets[0][15]}}, offsets[0]};
      REG_ROLL_OFF:  prdata = {{16{offsets[1][15]}}, offsets[1]};
      REG_YAW_OFF:   prdata = {{16{offsets[2][15]}}, offsets[2]};
      REG_AX_OFF:    prdata = {{16{offsets[3][15]}}, offsets[3]};
      REG_AY_OFF:    prdata = {{16{offsets[4][15]}}, offsets[4]};
      REG_AZ_OFF:    prdata = {{16{offsets[5][15]}}, offsets[5]};
      default:       prdata = '0;
    endcase
  end
endmodule

// ===== rtl/core/imu_cal_serdiv.sv =====
// Restoring divider that produces one quotient bit per cycle (magnitude in, magnitude out).
`timescale 1ns / 1ps
module imu_cal_serdiv (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [39:0] dividend,
  input  logic [16:0] divisor,
  output logic        done,
  output logic [39:0] quotient
);
  logic [39:0] q;
  logic [17:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [17:0] trial;

  assign trial = {rem[16:0], q[39]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd40;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
    end else if (busy) begin
      if (!trial[17]) begin
        rem <= trial;
        q   <= {q[38:0], 1'b1};
      end else begin
        rem <= {rem[16:0], q[39]};
        q   <= {q[38:0], 1'b0};
      end
    end
  end
  assign quotient = q;
endmodule

// ===== rtl/core/imu_cal_sqrt.sv =====
// Integer square root that retires one result bit per cycle.
`timescale 1ns / 1ps
module imu_cal_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [33:0] radicand,
  output logic        done,
  output logic [16:0] root
);
  logic [33:0] n;
  logic [18:0] rem;
  logic [16:0] r;
  logic [4:0]  cnt;
  logic        busy;
  logic [18:0] shifted;
  logic [18:0] trial;

  assign shifted = {rem[16:0], n[33:32]};
  assign trial   = shifted - {r, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd17;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n   <= radicand;
      rem <= '0;
      r   <= '0;
    end else if (busy) begin
      n <= {n[31:0], 2'b00};
      if (!trial[18]) begin
        rem <= trial;
        r   <= {r[15:0], 1'b1};
      end else begin
        rem <= shifted;
        r   <= {r[15:0], 1'b0};
      end
    end
  end
  assign root = r;
endmodule

// ===== verif/imu_sample_calibrator_top_tb.sv =====
// Self-checking testbench for the IMU sample calibrator: stream stimulus, prediction and compare.
`timescale 1ns / 1ps
module imu_sample_calibrator_top_tb;
  import imu_cal_pkg::*;

  localparam int Window = 25;
  localparam int WatchdogLimit = 20000;

  typedef struct packed {
    logic signed [15:0] mag_z, mag_y, mag_x;
    logic signed [15:0] accel_z, accel_y, accel_x;
    logic signed [15:0] gyro_z, gyro_y, gyro_x;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] average_z;
    logic [15:0] accel_magnitude;
    logic signed [15:0] body_accel_z, body_accel_y, body_accel_x;
    logic signed [15:0] yaw_rate, roll_rate, pitch_rate;
    logic signed [15:0] field_z, field_y, field_x;
  } calibrated_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [143:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [175:0] m_tdata;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  imu_sample_calibrator_top dut (.*);

  always #4 clk = ~clk;

  // Predictor state.
  logic signed [15:0] offsets [NumRegs];
  logic signed [15:0] z_ring [Window];
  longint z_sum;
  int ring_pos;

  sample_t pending_samples[$];
  calibrated_t expected_results[$];
  int error_count = 0;
  int idle_cycles = 0;
  bit stall_out = 0;
  int long_stall = 0;
  bit stall_in = 0;

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic longint floor_sqrt(longint n);
    longint r = 0;
    longint b = 64'sd1 <<< 60;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic calibrated_t calibrate(sample_t s);
    calibrated_t c;
    longint hi [3] = '{-2006, -2812, 4836};
    longint si [9] = '{947, -3, 10, -3, 1022, -23, 10, -23, 1034};
    longint d [3];
    longint m [3];
    longint bx, by, bz, zs;
    longint mg;
    d[0] = longint'(s.mag_x) * 100 - hi[0] * 16;
    d[1] = longint'(s.mag_y) * 100 - hi[1] * 16;
    d[2] = longint'(s.mag_z) * 100 - hi[2] * 16;
    for (int i = 0; i < 3; i++)
      m[i] = round_div(si[3*i] * d[0] + si[3*i+1] * d[1] + si[3*i+2] * d[2], 100000);
    c.field_x = clamp16(m[0]);
    c.field_y = clamp16(m[1]);
    c.field_z = clamp16(m[2]);
    c.pitch_rate = clamp16(round_div(longint'(s.gyro_x) * 1125
                                     - longint'(offsets[REG_PITCH_OFF]) * 1256, 1256));
    c.roll_rate = clamp16(round_div(longint'(s.gyro_y) * 1125
                                    - longint'(offsets[REG_ROLL_OFF]) * 1256, 1256));
    c.yaw_rate = clamp16(round_div(-longint'(s.gyro_z) * 1125
                                   - longint'(offsets[REG_YAW_OFF]) * 1256, 1256));
    bx = -longint'(s.accel_y) - offsets[REG_AX_OFF];
    by = -longint'(s.accel_x) - offsets[REG_AY_OFF];
    bz = longint'(s.accel_z) - offsets[REG_AZ_OFF];
    c.body_accel_x = clamp16(bx);
    c.body_accel_y = clamp16(by);
    c.body_accel_z = clamp16(bz);
    mg = floor_sqrt(bx * bx + by * by + bz * bz);
    c.accel_magnitude = (mg > 65535) ? 16'hFFFF : mg[15:0];
    zs = longint'(signed'(clamp16(bz)));
    z_sum = z_sum + zs - z_ring[ring_pos];
    c.average_z = clamp16(round_div(z_sum, Window));
    z_ring[ring_pos] = zs[15:0];
    ring_pos = (ring_pos + 1 >= Window) ? 0 : ring_pos + 1;
    return c;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Driver: offers the next pending item, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_samples.size() > 0 && !stall_in && $urandom_range(0, 9) < 7) begin
        s_tdata <= pending_samples.pop_front();
        s_tvalid <= 1;
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // Prediction happens on acceptance so register changes line up with items.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) expected_results.push_back(calibrate(s_tdata));
  end

  // Receiver readiness: random stalls plus a commanded long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (long_stall > 0) begin
      m_tready <= 0;
      long_stall <= long_stall - 1;
    end else if (stall_out) begin
      m_tready <= 0;
    end else begin
      case ($urandom_range(0, 19))
        0: m_tready <= 0;
        1, 2, 3: m_tready <= ($urandom_range(0, 30) == 0);
        default: m_tready <= 1;
      endcase
    end
  end

  // Monitor.
  always @(posedge clk) begin
    calibrated_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_results.size() == 0) begin
        $display("unexpected result %h at %0t", m_tdata, $realtime);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.field_x !== want.field_x) report_mismatch("field_x", got.field_x, want.field_x);
        if (got.field_y !== want.field_y) report_mismatch("field_y", got.field_y, want.field_y);
        if (got.field_z !== want.field_z) report_mismatch("field_z", got.field_z, want.field_z);
        if (got.pitch_rate !== want.pitch_rate)
          report_mismatch("pitch_rate", got.pitch_rate, want.pitch_rate);
        if (got.roll_rate !== want.roll_rate)
          report_mismatch("roll_rate", got.roll_rate, want.roll_rate);
        if (got.yaw_rate !== want.yaw_rate)
          report_mismatch("yaw_rate", got.yaw_rate, want.yaw_rate);
        if (got.body_accel_x !== want.body_accel_x)
          report_mismatch("body_accel_x", got.body_accel_x, want.body_accel_x);
        if (got.body_accel_y !== want.body_accel_y)
          report_mismatch("body_accel_y", got.body_accel_y, want.body_accel_y);
        if (got.body_accel_z !== want.body_accel_z)
          report_mismatch("body_accel_z", got.body_accel_z, want.body_accel_z);
        if (got.accel_magnitude !== want.accel_magnitude)
          report_mismatch("accel_magnitude", got.accel_magnitude, want.accel_magnitude);
        if (got.average_z !== want.average_z)
          report_mismatch("average_z", got.average_z, want.average_z);
      end
    end
  end

  // Watchdog on cycles without any accepted item or taken result.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_offset(reg_index_t idx, logic [15:0] value);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= {{16{value[15]}}, value};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    offsets[idx] = value;
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_random(int count);
    sample_t s;
    repeat (count) begin
      s = {pick_value(), pick_value(), pick_value(), pick_value(), pick_value(),
           pick_value(), pick_value(), pick_value(), pick_value()};
      pending_samples.push_back(s);
    end
  endtask

  task automatic set_all(logic [15:0] v0, logic [15:0] v1);
    write_offset(REG_PITCH_OFF, v0);
    write_offset(REG_ROLL_OFF, v1);
    write_offset(REG_YAW_OFF, v0);
    write_offset(REG_AX_OFF, v1);
    write_offset(REG_AY_OFF, v0);
    write_offset(REG_AZ_OFF, v1);
  endtask

  initial begin
    sample_t s;
    for (int i = 0; i < NumRegs; i++) offsets[i] = 0;
    for (int i = 0; i < Window; i++) z_ring[i] = 0;
    z_sum = 0;
    ring_pos = 0;
    repeat (3) @(posedge clk);
    rst <= 0;

    // Directed: zeros, extremes of every field, saturation of field and body acceleration values.
    pending_samples.push_back('0);
    pending_samples.push_back({9{16'h7FFF}});
    pending_samples.push_back({9{16'h8000}});
    pending_samples.push_back({9{16'hFFFF}});
    pending_samples.push_back({9{16'h0001}});
    pending_samples.push_back({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                               16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    pending_samples.push_back({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                               16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
    pending_samples.push_back({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                               16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
    // Hard-iron zero points of the magnetometer.
    s = '0;
    s.mag_x = -16'sd321;
    s.mag_y = -16'sd450;
    s.mag_z = 16'sd774;
    pending_samples.push_back(s);
    drain();

    // Extreme offsets push body accelerations past the 16-bit range.
    set_all(16'h7FFF, 16'h8000);
    pending_samples.push_back({9{16'h8000}});
    pending_samples.push_back({9{16'h7FFF}});
    pending_samples.push_back('0);
    queue_random(8);
    drain();

    // Long receiver hold-off while the sender keeps offering items.
    set_all(16'h8000, 16'h7FFF);
    queue_random(150);
    long_stall = 600;
    drain();

    set_all(16'(int'($urandom_range(0, 400)) - 200), 16'(int'($urandom_range(0, 400)) - 200));
    queue_random(300);
    drain();

    set_all(16'($urandom), 16'($urandom));
    queue_random(300);
    // Sender pauses until every result is out, then resumes.
    while (pending_samples.size() > 150) @(posedge clk);
    stall_in = 1;
    while (s_tvalid || expected_results.size() > 0) @(posedge clk);
    stall_in = 0;
    drain();

    set_all(16'h0000, 16'h0000);
    queue_random(270);
    drain();

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/imu_cal_pkg.sv
rtl/core/imu_cal_regs.sv
rtl/core/imu_cal_serdiv.sv
rtl/core/imu_cal_sqrt.sv
rtl/core/imu_sample_calibrator_top.sv
verif/imu_sample_calibrator_top_tb.sv
